// ===== sv/prrs_pkg.sv =====
// Shared types and constants for the priority round-robin scheduler.
package prrs_pkg;

    localparam int DEF_SLOTS = 16;
    localparam int ID_W      = 8;
    localparam int PRIO_W    = 8;
    localparam int DUR_W     = 16;

    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic              write;
        logic              tick;
        logic              run;
        logic              finish;
        logic [DUR_W-1:0]  new_rem;
        logic [ID_W-1:0]   wr_id;
        logic [PRIO_W-1:0] wr_prio;
        logic [DUR_W-1:0]  wr_rem;
        logic [PRIO_W-1:0] ref_prio;
    } t_cell_ctl;

    // Status from one cell; the sel_ fields are zero unless the cell holds the scan token.
    typedef struct packed {
        logic              wtok;
        logic              stok;
        logic              sel_active;
        logic [PRIO_W-1:0] sel_prio;
        logic [ID_W-1:0]   sel_id;
        logic [DUR_W-1:0]  sel_rem;
        logic              lower;
        logic              other_active;
    } t_cell_stat;

endpackage

// ===== sv/prrs_cell.sv =====
// One task slot of the scheduler chain, carrying the write and scan tokens.
module prrs_cell #(
    parameter bit FIRST = 1'b0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wtok_prev,
    input  logic                 i_stok_prev,
    input  prrs_pkg::t_cell_ctl  i_ctl,
    output prrs_pkg::t_cell_stat o_stat
);
    import prrs_pkg::*;

    logic              r_active;
    logic              r_wtok;
    logic              r_stok;
    logic [ID_W-1:0]   r_id;
    logic [PRIO_W-1:0] r_prio;
    logic [DUR_W-1:0]  r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_wtok   <= FIRST;
            r_stok   <= FIRST;
        end else begin
            if (i_ctl.write) begin
                r_wtok <= i_wtok_prev;
                if (r_wtok) begin
                    r_active <= 1'b1;
                end
            end
            if (i_ctl.tick) begin
                r_stok <= i_stok_prev;
                if (r_stok && i_ctl.run && i_ctl.finish) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.write && r_wtok) begin
            r_id   <= i_ctl.wr_id;
            r_prio <= i_ctl.wr_prio;
            r_rem  <= i_ctl.wr_rem;
        end else if (i_ctl.tick && r_stok && i_ctl.run) begin
            r_rem <= i_ctl.new_rem;
        end
    end

    always_comb begin
        o_stat.wtok         = r_wtok;
        o_stat.stok         = r_stok;
        o_stat.sel_active   = r_stok & r_active;
        o_stat.sel_prio     = r_stok ? r_prio : '0;
        o_stat.sel_id       = r_stok ? r_id : '0;
        o_stat.sel_rem      = r_stok ? r_rem : '0;
        o_stat.lower        = r_active && (r_prio < i_ctl.ref_prio);
        o_stat.other_active = r_active & ~r_stok;
    end

endmodule

// ===== sv/priority_round_robin_scheduler.sv =====
// Priority round-robin scheduler: a chain of slot cells with a shared controller.
// A register beat writes its task into the next slot in circular order, replacing
// anything there; a tick beat examines the slot under the circular scan pointer and
// runs that task one unit when it is active and no active slot has a lower priority
// value. Both pointers are one-hot tokens handed from cell to cell. The accept of an
// item captures the scanned slot; in S_EXEC its priority is compared against every
// cell in parallel and, once the output is free, the update and result commit.
// One item is in work at a time; the result register lets a new item be accepted
// while the previous result waits. Exactly one result beat is produced per item.
module priority_round_robin_scheduler #(
    parameter int SLOTS = prrs_pkg::DEF_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // new_id[7:0], new_priority[15:8], new_duration[31:16]
    input  logic        s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // run_id[7:0], left_units[23:8], task_done[24],
                                       // all_idle[25], zero[31:26]
    output logic        m_axis_tuser   // executed
);
    import prrs_pkg::*;

    t_state            r_state, n_state;
    logic              r_cmd;
    logic [ID_W-1:0]   r_wr_id;
    logic [PRIO_W-1:0] r_wr_prio;
    logic [DUR_W-1:0]  r_wr_rem;
    logic              r_ref_active;
    logic [PRIO_W-1:0] r_ref_prio;
    logic [ID_W-1:0]   r_ref_id;
    logic [DUR_W-1:0]  r_ref_rem;

    logic              r_out_valid;
    logic [31:0]       r_out_data;
    logic              r_out_user;

    t_cell_ctl         w_ctl;
    t_cell_stat        w_stat [SLOTS];
    logic [SLOTS-1:0]  w_wtok;
    logic [SLOTS-1:0]  w_stok;

    logic              w_sel_active;
    logic [PRIO_W-1:0] w_sel_prio;
    logic [ID_W-1:0]   w_sel_id;
    logic [DUR_W-1:0]  w_sel_rem;
    logic              w_blocked;
    logic              w_others;

    logic              w_accept;
    logic              w_out_free;
    logic              w_commit;
    logic              w_run;
    logic [DUR_W-1:0]  w_new_rem;
    logic              w_finish;
    logic              w_idle_after;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            prrs_cell #(
                .FIRST (g == 0)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_wtok_prev (w_wtok[(g + SLOTS - 1) % SLOTS]),
                .i_stok_prev (w_stok[(g + SLOTS - 1) % SLOTS]),
                .i_ctl       (w_ctl),
                .o_stat      (w_stat[g])
            );
            assign w_wtok[g] = w_stat[g].wtok;
            assign w_stok[g] = w_stat[g].stok;
        end
    endgenerate

    // AND-OR select of the scanned slot, plus the compare and activity summaries.
    always_comb begin
        w_sel_active = 1'b0;
        w_sel_prio   = '0;
        w_sel_id     = '0;
        w_sel_rem    = '0;
        w_blocked    = 1'b0;
        w_others     = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            w_sel_active = w_sel_active | w_stat[i].sel_active;
            w_sel_prio   = w_sel_prio | w_stat[i].sel_prio;
            w_sel_id     = w_sel_id | w_stat[i].sel_id;
            w_sel_rem    = w_sel_rem | w_stat[i].sel_rem;
            w_blocked    = w_blocked | w_stat[i].lower;
            w_others     = w_others | w_stat[i].other_active;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign w_run        = r_ref_active && !w_blocked;
    assign w_new_rem    = (r_ref_rem > DUR_W'(1)) ? r_ref_rem - DUR_W'(1) : '0;
    assign w_finish     = (w_new_rem == '0);
    assign w_idle_after = !w_others && (!r_ref_active || (w_run && w_finish));

    always_comb begin
        n_state  = r_state;
        w_commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    w_commit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ctl.write    = w_commit && (r_cmd == CMD_REGISTER);
        w_ctl.tick     = w_commit && (r_cmd == CMD_TICK);
        w_ctl.run      = w_run;
        w_ctl.finish   = w_finish;
        w_ctl.new_rem  = w_new_rem;
        w_ctl.wr_id    = r_wr_id;
        w_ctl.wr_prio  = r_wr_prio;
        w_ctl.wr_rem   = r_wr_rem;
        w_ctl.ref_prio = r_ref_prio;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd        <= s_axis_tuser;
            r_wr_id      <= s_axis_tdata[7:0];
            r_wr_prio    <= s_axis_tdata[15:8];
            r_wr_rem     <= s_axis_tdata[31:16];
            r_ref_active <= w_sel_active;
            r_ref_prio   <= w_sel_prio;
            r_ref_id     <= w_sel_id;
            r_ref_rem    <= w_sel_rem;
        end
        if (w_commit) begin
            if (r_cmd == CMD_REGISTER) begin
                r_out_user <= 1'b0;
                r_out_data <= '0;
            end else if (w_run) begin
                r_out_user <= 1'b1;
                r_out_data <= {6'b0, w_idle_after, w_finish, w_new_rem, r_ref_id};
            end else begin
                r_out_user <= 1'b0;
                r_out_data <= {6'b0, w_idle_after, 1'b0, {DUR_W{1'b0}}, {ID_W{1'b0}}};
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

`ifndef SYNTHESIS
    a_wtok_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_wtok))
        else $error("write token not one-hot");

    a_stok_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_stok))
        else $error("scan token not one-hot");

    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_user) |-> (r_out_data[24:0] == 25'd0))
        else $error("result without a run carries task fields");

    a_register_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (r_cmd == CMD_REGISTER)) |=> (r_out_valid && !r_out_data[25]))
        else $error("register result reports all slots idle");
`endif

endmodule
